// ===== rtl/core/cdh_pkg.sv =====
// Shared constants, control types and a helper function of the centroid distance histogram.
package cdh_pkg;

    localparam int COORD_W    = 12;
    localparam int MAX_POINTS = 4096;
    localparam int ADDR_W     = 12;
    localparam int CNT_W      = 13;
    localparam int SUM_W      = 24;
    localparam int SQ_W       = 25;
    localparam int DIST_W     = 21;
    localparam int DSUM_W     = 33;
    localparam int NUM_BINS   = 100;
    localparam int BIN_AW     = 7;
    localparam int BCNT_W     = 13;
    localparam int VAL_W      = 15;
    localparam int PROD_W     = 28;
    localparam int FRAC_W     = 16;

    localparam int DVD_W      = 37;
    localparam int DVS_W      = 21;
    localparam int DIV_CNT_W  = 6;

    localparam int RAD_W      = 42;
    localparam int ROOT_W     = 21;
    localparam int SREM_W     = 24;
    localparam int SQRT_CNT_W = 5;

    localparam int BIN_SCALE  = 25600;
    localparam int RATIO_HI   = 194642;
    localparam int RATIO_LO   = 1966;
    localparam int ROUND_OFS  = 196608;

    localparam logic [2:0] DV_CX    = 3'd0;
    localparam logic [2:0] DV_CY    = 3'd1;
    localparam logic [2:0] DV_MEAN  = 3'd2;
    localparam logic [2:0] DV_RATIO = 3'd3;
    localparam logic [2:0] DV_BIN   = 3'd4;

    typedef struct packed {
        logic       load_pt;
        logic       clr_wr;
        logic       idx_clr;
        logic       idx_inc;
        logic       div_start;
        logic [2:0] div_sel;
        logic       ld_cx;
        logic       ld_cy;
        logic       ld_mean;
        logic       xy_rd;
        logic       sq_ld;
        logic       sqrt_start;
        logic       dist_wr;
        logic       dist_rd;
        logic       bin_ld;
        logic       hb_rd;
        logic       hb_inc;
        logic       sel_rd;
        logic       prod_ld;
        logic       out_ld;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic idx_last;
        logic idx_clr_end;
        logic div_busy;
        logic sqrt_busy;
        logic mean_zero;
        logic hist_zero;
        logic out_free;
    } t_sts;

    // ratio has 16 fraction bits; bins are 0.03 wide, rounded half up
    function automatic logic [BIN_AW-1:0] bin_of(input logic [DVD_W-1:0] q);
        logic [25:0] v;
        logic [8:0]  t;
        logic [18:0] p;
        v = 26'(q[17:0]) * 26'd200 + 26'(ROUND_OFS);
        t = v[25:17];
        p = 19'(t) * 19'd683;
        if (q >= DVD_W'(RATIO_HI)) begin
            return BIN_AW'(NUM_BINS - 1);
        end else if (q <= DVD_W'(RATIO_LO)) begin
            return '0;
        end else if (p[18:11] > 8'(NUM_BINS - 1)) begin
            return BIN_AW'(NUM_BINS - 1);
        end
        return p[17:11];
    endfunction

endpackage

// ===== rtl/core/cdh_if.sv =====
// Request and result channel interfaces.
interface cdh_in_if import cdh_pkg::*;;
    logic               valid;
    logic               ready;
    logic               op;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic               last_point;
    logic [BIN_AW-1:0]  bin_select;
    modport source (output valid, op, point_x, point_y, last_point, bin_select, input ready);
    modport sink   (input valid, op, point_x, point_y, last_point, bin_select, output ready);
endinterface

interface cdh_out_if import cdh_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BIN_AW-1:0] bin_number;
    logic [VAL_W-1:0]  bin_value;
    modport source (output valid, bin_number, bin_value, input ready);
    modport sink   (input valid, bin_number, bin_value, output ready);
endinterface

// ===== rtl/core/cdh_ram.sv =====
// Generic simple dual port RAM with registered read.
module cdh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/cdh_div.sv =====
// Restoring divider, one quotient bit per cycle.
module cdh_div import cdh_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dvd,
    input  logic [DVS_W-1:0] i_dvs,
    output logic             o_busy,
    output logic [DVD_W-1:0] o_quo
);
    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]     r_rem;
    logic [DVD_W-1:0]     r_quo;
    logic [DVS_W-1:0]     r_dvs;
    logic [DVS_W:0]       rem_sh;
    logic                 ge;

    assign rem_sh = {r_rem, r_quo[DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DVD_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dvd;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            r_rem <= ge ? DVS_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
endmodule

// ===== rtl/core/cdh_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
module cdh_sqrt import cdh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_rad,
    output logic              o_busy,
    output logic [ROOT_W-1:0] o_root
);
    logic                  r_busy;
    logic [SQRT_CNT_W-1:0] r_cnt;
    logic [SREM_W-1:0]     r_rem;
    logic [RAD_W-1:0]      r_rad;
    logic [ROOT_W-1:0]     r_root;
    logic [SREM_W-1:0]     rem_sh;
    logic [SREM_W-1:0]     trial;
    logic                  ge;

    assign rem_sh = {r_rem[SREM_W-3:0], r_rad[RAD_W-1:RAD_W-2]};
    assign trial  = SREM_W'({r_root, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= SQRT_CNT_W'(ROOT_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_rad  <= i_rad;
            r_root <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? rem_sh - trial : rem_sh;
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_root <= {r_root[ROOT_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;
endmodule

// ===== rtl/core/cdh_dp.sv =====
// Datapath: point stores, sums, centroid, distances, bin memory and result register.
module cdh_dp import cdh_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [COORD_W-1:0] i_point_x,
    input  logic [COORD_W-1:0] i_point_y,
    input  logic [BIN_AW-1:0]  i_bin_select,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [BIN_AW-1:0]  o_bin_number,
    output logic [VAL_W-1:0]   o_bin_value
);
    logic [CNT_W-1:0]   r_count;
    logic [SUM_W-1:0]   r_sum_x;
    logic [SUM_W-1:0]   r_sum_y;
    logic [DSUM_W-1:0]  r_dsum;
    logic [DIST_W-1:0]  r_mean;
    logic [CNT_W-1:0]   r_hist_total;
    logic [ADDR_W-1:0]  r_idx;
    logic [COORD_W-1:0] r_cx;
    logic [COORD_W-1:0] r_cy;
    logic [SQ_W-1:0]    r_sq;
    logic [BIN_AW-1:0]  r_bin;
    logic [BIN_AW-1:0]  r_sel;
    logic [PROD_W-1:0]  r_prod;
    logic               r_out_valid;
    logic [BIN_AW-1:0]  r_out_num;
    logic [VAL_W-1:0]   r_out_val;

    logic               pt_we;
    logic [COORD_W-1:0] x_rdata;
    logic [COORD_W-1:0] y_rdata;
    logic [DIST_W-1:0]  d_rdata;
    logic [BCNT_W-1:0]  b_rdata;
    logic               b_we;
    logic [BIN_AW-1:0]  b_waddr;
    logic [BCNT_W-1:0]  b_wdata;
    logic [BIN_AW-1:0]  b_raddr;
    logic [BIN_AW-1:0]  sel_sat;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [DVD_W-1:0]   dvd;
    logic [DVS_W-1:0]   dvs;
    logic               div_busy;
    logic [DVD_W-1:0]   quo;
    logic               sqrt_busy;
    logic [ROOT_W-1:0]  root;
    logic               out_free;

    assign pt_we   = i_cmd.load_pt && (r_count < CNT_W'(MAX_POINTS));
    assign sel_sat = (i_bin_select > BIN_AW'(NUM_BINS - 1)) ? BIN_AW'(NUM_BINS - 1)
                                                              : i_bin_select;
    assign dx = (x_rdata > r_cx) ? x_rdata - r_cx : r_cx - x_rdata;
    assign dy = (y_rdata > r_cy) ? y_rdata - r_cy : r_cy - y_rdata;

    assign b_we    = i_cmd.clr_wr || i_cmd.hb_inc;
    assign b_waddr = i_cmd.clr_wr ? r_idx[BIN_AW-1:0] : r_bin;
    assign b_wdata = i_cmd.clr_wr ? '0 : b_rdata + 1'b1;
    assign b_raddr = i_cmd.sel_rd ? sel_sat : r_bin;

    always_comb begin
        case (i_cmd.div_sel)
            DV_CX: begin
                dvd = DVD_W'(r_sum_x);
                dvs = DVS_W'(r_count);
            end
            DV_CY: begin
                dvd = DVD_W'(r_sum_y);
                dvs = DVS_W'(r_count);
            end
            DV_MEAN: begin
                dvd = DVD_W'(r_dsum);
                dvs = DVS_W'(r_count);
            end
            DV_RATIO: begin
                dvd = {d_rdata, FRAC_W'(0)};
                dvs = r_mean;
            end
            DV_BIN: begin
                dvd = DVD_W'(r_prod);
                dvs = DVS_W'(r_hist_total);
            end
            default: begin
                dvd = '0;
                dvs = '0;
            end
        endcase
    end

    cdh_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_x_ram (
        .i_clk(i_clk), .i_we(pt_we), .i_waddr(r_count[ADDR_W-1:0]), .i_wdata(i_point_x),
        .i_re(i_cmd.xy_rd), .i_raddr(r_idx), .o_rdata(x_rdata)
    );

    cdh_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_y_ram (
        .i_clk(i_clk), .i_we(pt_we), .i_waddr(r_count[ADDR_W-1:0]), .i_wdata(i_point_y),
        .i_re(i_cmd.xy_rd), .i_raddr(r_idx), .o_rdata(y_rdata)
    );

    cdh_ram #(.WIDTH(DIST_W), .DEPTH(MAX_POINTS)) u_dist_ram (
        .i_clk(i_clk), .i_we(i_cmd.dist_wr), .i_waddr(r_idx), .i_wdata(root),
        .i_re(i_cmd.dist_rd), .i_raddr(r_idx), .o_rdata(d_rdata)
    );

    cdh_ram #(.WIDTH(BCNT_W), .DEPTH(NUM_BINS)) u_bin_ram (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_waddr), .i_wdata(b_wdata),
        .i_re(i_cmd.hb_rd || i_cmd.sel_rd), .i_raddr(b_raddr), .o_rdata(b_rdata)
    );

    cdh_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_dvd(dvd), .i_dvs(dvs), .o_busy(div_busy), .o_quo(quo)
    );

    cdh_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.sqrt_start),
        .i_rad({1'b0, r_sq, FRAC_W'(0)}), .o_busy(sqrt_busy), .o_root(root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_sum_x      <= '0;
            r_sum_y      <= '0;
            r_dsum       <= '0;
            r_mean       <= '0;
            r_hist_total <= '0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (pt_we) begin
                r_count <= r_count + 1'b1;
                r_sum_x <= r_sum_x + SUM_W'(i_point_x);
                r_sum_y <= r_sum_y + SUM_W'(i_point_y);
            end
            if (i_cmd.dist_wr) begin
                r_dsum <= r_dsum + DSUM_W'(root);
            end
            if (i_cmd.ld_mean) begin
                r_mean <= quo[DIST_W-1:0];
            end
            if (i_cmd.finish) begin
                r_hist_total <= r_count;
                r_count      <= '0;
                r_sum_x      <= '0;
                r_sum_y      <= '0;
                r_dsum       <= '0;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_cx) begin
            r_cx <= quo[COORD_W-1:0];
        end
        if (i_cmd.ld_cy) begin
            r_cy <= quo[COORD_W-1:0];
        end
        if (i_cmd.sq_ld) begin
            r_sq <= SQ_W'(dx) * SQ_W'(dx) + SQ_W'(dy) * SQ_W'(dy);
        end
        if (i_cmd.bin_ld) begin
            r_bin <= (r_mean == '0) ? '0 : bin_of(quo);
        end
        if (i_cmd.sel_rd) begin
            r_sel <= sel_sat;
        end
        if (i_cmd.prod_ld) begin
            r_prod <= PROD_W'(b_rdata) * PROD_W'(BIN_SCALE);
        end
        if (i_cmd.out_ld) begin
            r_out_num <= r_sel;
            r_out_val <= (r_hist_total == '0) ? '0 : quo[VAL_W-1:0];
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    assign o_sts.idx_last    = {1'b0, r_idx} == (r_count - 1'b1);
    assign o_sts.idx_clr_end = r_idx == ADDR_W'(NUM_BINS - 1);
    assign o_sts.div_busy    = div_busy;
    assign o_sts.sqrt_busy   = sqrt_busy;
    assign o_sts.mean_zero   = r_mean == '0;
    assign o_sts.hist_zero   = r_hist_total == '0;
    assign o_sts.out_free    = out_free;

    assign o_out_valid  = r_out_valid;
    assign o_bin_number = r_out_num;
    assign o_bin_value  = r_out_val;
endmodule

// ===== rtl/core/cdh_ctrl.sv =====
// Controller state machine sequencing loads, histogram computation and bin reads.
module cdh_ctrl import cdh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_op,
    input  logic i_last,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CLR  = 5'd1;
    localparam logic [4:0] S_DVX  = 5'd2;
    localparam logic [4:0] S_WX   = 5'd3;
    localparam logic [4:0] S_DVY  = 5'd4;
    localparam logic [4:0] S_WY   = 5'd5;
    localparam logic [4:0] S_XRD  = 5'd6;
    localparam logic [4:0] S_XSQ  = 5'd7;
    localparam logic [4:0] S_SQS  = 5'd8;
    localparam logic [4:0] S_SQW  = 5'd9;
    localparam logic [4:0] S_DWR  = 5'd10;
    localparam logic [4:0] S_DVM  = 5'd11;
    localparam logic [4:0] S_WM   = 5'd12;
    localparam logic [4:0] S_RRD  = 5'd13;
    localparam logic [4:0] S_RDV  = 5'd14;
    localparam logic [4:0] S_RWT  = 5'd15;
    localparam logic [4:0] S_HRD  = 5'd16;
    localparam logic [4:0] S_HWR  = 5'd17;
    localparam logic [4:0] S_BMU  = 5'd18;
    localparam logic [4:0] S_BDV  = 5'd19;
    localparam logic [4:0] S_BWT  = 5'd20;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (!i_op) begin
                        o_cmd.load_pt = 1'b1;
                        if (i_last) begin
                            o_cmd.idx_clr = 1'b1;
                            n_state = S_CLR;
                        end
                    end else begin
                        o_cmd.sel_rd = 1'b1;
                        n_state = S_BMU;
                    end
                end
            end
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.idx_clr_end) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = S_DVX;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_DVX: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DV_CX;
                n_state = S_WX;
            end
            S_WX: begin
                if (!i_sts.div_busy) begin
                    o_cmd.ld_cx = 1'b1;
                    n_state = S_DVY;
                end
            end
            S_DVY: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DV_CY;
                n_state = S_WY;
            end
            S_WY: begin
                if (!i_sts.div_busy) begin
                    o_cmd.ld_cy = 1'b1;
                    n_state = S_XRD;
                end
            end
            S_XRD: begin
                o_cmd.xy_rd = 1'b1;
                n_state = S_XSQ;
            end
            S_XSQ: begin
                o_cmd.sq_ld = 1'b1;
                n_state = S_SQS;
            end
            S_SQS: begin
                o_cmd.sqrt_start = 1'b1;
                n_state = S_SQW;
            end
            S_SQW: begin
                if (!i_sts.sqrt_busy) begin
                    n_state = S_DWR;
                end
            end
            S_DWR: begin
                o_cmd.dist_wr = 1'b1;
                if (i_sts.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = S_DVM;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_XRD;
                end
            end
            S_DVM: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DV_MEAN;
                n_state = S_WM;
            end
            S_WM: begin
                if (!i_sts.div_busy) begin
                    o_cmd.ld_mean = 1'b1;
                    n_state = S_RRD;
                end
            end
            S_RRD: begin
                o_cmd.dist_rd = 1'b1;
                n_state = S_RDV;
            end
            S_RDV: begin
                if (i_sts.mean_zero) begin
                    o_cmd.bin_ld = 1'b1;
                    n_state = S_HRD;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DV_RATIO;
                    n_state = S_RWT;
                end
            end
            S_RWT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.bin_ld = 1'b1;
                    n_state = S_HRD;
                end
            end
            S_HRD: begin
                o_cmd.hb_rd = 1'b1;
                n_state = S_HWR;
            end
            S_HWR: begin
                o_cmd.hb_inc = 1'b1;
                if (i_sts.idx_last) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_RRD;
                end
            end
            S_BMU: begin
                o_cmd.prod_ld = 1'b1;
                n_state = S_BDV;
            end
            S_BDV: begin
                if (!i_sts.hist_zero) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DV_BIN;
                end
                n_state = S_BWT;
            end
            S_BWT: begin
                if (!i_sts.div_busy && i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/core/centroid_distance_histogram.sv =====
// Centroid distance histogram top level: controller, datapath and channel ports.
// Point requests (op 0) are taken one per cycle while idle; up to 4096 points are stored.
// A last point starts the computation for n points (clear of the 100 bins, centroid x and y
// divides, a root per point, the mean divide, then a ratio divide and bin update per point,
// with no ratio divide at zero mean); no request is taken meanwhile.
// A bin read (op 1) returns bin count * 25600 / point total (zero with no histogram yet).
module centroid_distance_histogram import cdh_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cdh_in_if.sink    i_in,
    cdh_out_if.source o_out
);
    t_cmd cmd;
    t_sts sts;

    cdh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_op    (i_in.op),
        .i_last  (i_in.last_point),
        .o_ready (i_in.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cdh_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_point_x    (i_in.point_x),
        .i_point_y    (i_in.point_y),
        .i_bin_select (i_in.bin_select),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_bin_number (o_out.bin_number),
        .o_bin_value  (o_out.bin_value)
    );
endmodule

// ===== tb/tb_centroid_distance_histogram.sv =====
// Self-checking testbench for the centroid distance histogram: directed table, then random contours.
`timescale 1ns / 1ps

module tb_centroid_distance_histogram;
    import cdh_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int HIST_BINS    = 100;

    typedef struct {
        bit                op;
        bit [COORD_W-1:0]  x;
        bit [COORD_W-1:0]  y;
        bit                last;
        bit [BIN_AW-1:0]   sel;
        bit                typed;
        bit [BIN_AW-1:0]   t_num;
        bit [VAL_W-1:0]    t_val;
    } t_req;

    typedef struct {
        bit [BIN_AW-1:0] num;
        bit [VAL_W-1:0]  val;
    } t_bin_read;

    logic i_clk;
    logic i_rst_n;

    cdh_in_if  i_in ();
    cdh_out_if o_out ();

    centroid_distance_histogram DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out)
    );

    // shadow copy of the block's state
    bit [COORD_W-1:0] pts_x [MAX_POINTS];
    bit [COORD_W-1:0] pts_y [MAX_POINTS];
    longint unsigned  pts_dist [MAX_POINTS];
    int unsigned      hist_cnt [HIST_BINS];
    int unsigned      pts_n;
    longint unsigned  acc_x;
    longint unsigned  acc_y;
    int unsigned      hist_n;

    t_bin_read   pending_reads [$];
    t_req        cur;
    t_req        dir_tab [$];
    int          snd_idle_pct;
    int          rcv_idle_pct;
    int          hold_left;
    int          mismatches;
    int          cycles;
    int          items;
    int          rounds;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic int unsigned ratio_bin(input longint unsigned ratio);
        longint unsigned b;
        if (ratio * 100 > 64'd297 * 65536) return HIST_BINS - 1;
        if (ratio * 100 < 64'd3 * 65536) return 0;
        b = (ratio * 200 + 64'd3 * 65536) / (64'd6 * 65536);
        if (b > HIST_BINS - 1) b = HIST_BINS - 1;
        return int'(b);
    endfunction

    function automatic void build_histogram();
        longint unsigned cx, cy, dx, dy, dsum, mean;
        int unsigned b;
        dsum = 0;
        for (int i = 0; i < HIST_BINS; i++) hist_cnt[i] = 0;
        cx = acc_x / pts_n;
        cy = acc_y / pts_n;
        for (int i = 0; i < pts_n; i++) begin
            dx = pts_x[i] > cx ? pts_x[i] - cx : cx - pts_x[i];
            dy = pts_y[i] > cy ? pts_y[i] - cy : cy - pts_y[i];
            pts_dist[i] = int_sqrt((dx * dx + dy * dy) << 16);
            dsum += pts_dist[i];
        end
        mean = dsum / pts_n;
        for (int i = 0; i < pts_n; i++) begin
            b = 0;
            if (mean != 0) b = ratio_bin((pts_dist[i] << 16) / mean);
            hist_cnt[b]++;
        end
        hist_n = pts_n;
        pts_n = 0;
        acc_x = 0;
        acc_y = 0;
    endfunction

    function automatic void predict_request(input t_req r);
        t_bin_read e;
        int unsigned s;
        if (!r.op) begin
            if (pts_n < MAX_POINTS) begin
                pts_x[pts_n] = r.x;
                pts_y[pts_n] = r.y;
                acc_x += r.x;
                acc_y += r.y;
                pts_n++;
            end
            if (r.last && pts_n != 0) build_histogram();
        end else begin
            s = r.sel > HIST_BINS - 1 ? HIST_BINS - 1 : r.sel;
            e.num = BIN_AW'(s);
            e.val = hist_n == 0 ? '0 : VAL_W'((longint'(hist_cnt[s]) * 25600) / hist_n);
            if (r.typed) begin
                e.num = r.t_num;
                e.val = r.t_val;
            end
            pending_reads = {pending_reads, e};
        end
    endfunction

    always @(posedge i_clk) begin
        t_bin_read e;
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
        if (i_rst_n && i_in.valid && i_in.ready) predict_request(cur);
        if (i_rst_n && o_out.valid && o_out.ready) begin
            if (pending_reads.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: bin %0d value %0d",
                             o_out.bin_number, o_out.bin_value);
            end else begin
                e = pending_reads.pop_front();
                if (o_out.bin_number !== e.num || o_out.bin_value !== e.val) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("bin read: expected %0d/%0d, got %0d/%0d",
                                 e.num, e.val, o_out.bin_number, o_out.bin_value);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            o_out.ready = 1'b0;
            hold_left--;
        end else begin
            o_out.ready = $urandom_range(0, 99) >= rcv_idle_pct;
        end
    end

    function automatic t_req mk(input bit op, input int x, input int y, input bit last,
                                input int sel, input bit typed = 0,
                                input int num = 0, input int val = 0);
        t_req r;
        r.op = op;
        r.x = COORD_W'(x);
        r.y = COORD_W'(y);
        r.last = last;
        r.sel = BIN_AW'(sel);
        r.typed = typed;
        r.t_num = BIN_AW'(num);
        r.t_val = VAL_W'(val);
        return r;
    endfunction

    task automatic send_req(input t_req r);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in.valid = 1'b0;
            @(negedge i_clk);
        end
        cur = r;
        i_in.op = r.op;
        i_in.point_x = r.x;
        i_in.point_y = r.y;
        i_in.last_point = r.last;
        i_in.bin_select = r.sel;
        i_in.valid = 1'b1;
        do @(posedge i_clk); while (!i_in.ready);
        items++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in.valid = 1'b0;
        while (pending_reads.size() != 0) @(negedge i_clk);
    endtask

    task automatic send_contour(input int n, input int shape);
        int cx, cy, rad, x, y;
        cx = $urandom_range(0, 4095);
        cy = $urandom_range(0, 4095);
        rad = $urandom_range(1, 2047);
        for (int i = 0; i < n; i++) begin
            case (shape)
                0: begin
                    x = cx + $urandom_range(0, 2 * rad) - rad;
                    y = cy + $urandom_range(0, 2 * rad) - rad;
                    x = x < 0 ? 0 : (x > 4095 ? 4095 : x);
                    y = y < 0 ? 0 : (y > 4095 ? 4095 : y);
                end
                1: begin
                    x = $urandom_range(0, 4095);
                    y = $urandom_range(0, 4095);
                end
                default: begin
                    x = cx;
                    y = cy;
                end
            endcase
            // occasional bin read in the middle of a contour
            if ($urandom_range(0, 99) < 8)
                send_req(mk(1, $urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 127)));
            send_req(mk(0, x, y, i == n - 1, $urandom_range(0, 127)));
        end
    endtask

    initial begin
        int n;
        i_rst_n = 1'b0;
        i_in.valid = 1'b0;
        i_in.op = 1'b0;
        i_in.point_x = '0;
        i_in.point_y = '0;
        i_in.last_point = 1'b0;
        i_in.bin_select = '0;
        o_out.ready = 1'b0;
        cur = mk(0, 0, 0, 0, 0);
        pts_n = 0;
        acc_x = 0;
        acc_y = 0;
        hist_n = 0;
        for (int i = 0; i < HIST_BINS; i++) hist_cnt[i] = 0;
        mismatches = 0;
        cycles = 0;
        items = 0;
        rounds = 0;
        hold_left = 0;
        snd_idle_pct = 38;
        rcv_idle_pct = 75;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        dir_tab = {dir_tab, mk(1, 0, 0, 0, 0, 1, 0, 0)};
        dir_tab = {dir_tab, mk(1, 0, 0, 0, 127, 1, 99, 0)};
        dir_tab = {dir_tab, mk(1, 4095, 4095, 1, 50, 1, 50, 0)};
        dir_tab = {dir_tab, mk(0, 5, 5, 1, 0)};
        dir_tab = {dir_tab, mk(1, 0, 0, 0, 0, 1, 0, 25600)};
        dir_tab = {dir_tab, mk(1, 0, 0, 0, 1, 1, 1, 0)};
        dir_tab = {dir_tab, mk(0, 0, 0, 0, 0)};
        dir_tab = {dir_tab, mk(0, 4095, 4095, 1, 127)};
        dir_tab = {dir_tab, mk(1, 0, 0, 0, 33)};
        dir_tab = {dir_tab, mk(1, 0, 0, 0, 34)};
        dir_tab = {dir_tab, mk(1, 0, 0, 0, 100)};
        dir_tab = {dir_tab, mk(0, 7, 9, 0, 0)};
        dir_tab = {dir_tab, mk(0, 7, 9, 0, 0)};
        dir_tab = {dir_tab, mk(0, 7, 9, 1, 0)};
        dir_tab = {dir_tab, mk(1, 0, 0, 0, 0, 1, 0, 25600)};
        for (int i = 0; i < 5; i++) dir_tab = {dir_tab, mk(0, 100 + i, 100, 0, 0)};
        dir_tab = {dir_tab, mk(0, 4095, 0, 1, 0)};
        dir_tab = {dir_tab, mk(1, 0, 0, 0, 0)};
        dir_tab = {dir_tab, mk(1, 0, 0, 0, 99)};
        foreach (dir_tab[i]) send_req(dir_tab[i]);

        items = 0;
        while (items < 1000) begin
            if (items >= 330 && items < 660) begin
                snd_idle_pct = 75;
                rcv_idle_pct = 38;
            end else if (items >= 660) begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            if (rounds == 0 || $urandom_range(0, 29) == 0) begin
                // receiver holds off while reads keep coming
                i_in.valid = 1'b0;
                @(posedge i_clk);
                hold_left = 400;
                @(negedge i_clk);
                for (int i = 0; i < 12; i++) send_req(mk(1, 0, 0, 0, $urandom_range(0, 99)));
            end
            if (rounds == 1 || $urandom_range(0, 24) == 0) wait_drained();
            rounds++;
            n = $urandom_range(0, 19) == 0 ? $urandom_range(60, 250) : $urandom_range(2, 24);
            send_contour(n, $urandom_range(0, 9) == 0 ? 2 : $urandom_range(0, 1));
            repeat ($urandom_range(1, 5))
                send_req(mk(1, $urandom, $urandom, $urandom_range(0, 1),
                            $urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                                      : $urandom_range(0, 99)));
        end
        i_in.valid = 1'b0;

        wait_drained();
        repeat (200) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
